// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// Included by bare file name; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sha_pkg.sv =====
// Shared types, constants and round functions of the SHA-256 hasher.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        CORE_HOLD,
        CORE_BYTE,
        CORE_ROUND,
        CORE_UPDATE,
        CORE_INIT
    } core_op_t;

    typedef struct packed {
        core_op_t    op;
        logic [7:0]  byte_val;
        logic [5:0]  round;
    } core_ctl_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [7:0] PAD_ZERO = 8'h00;
    localparam logic [5:0] LAST_SLOT = 6'd63;
    localparam logic [5:0] LEN_START_SLOT = 6'd55;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam logic [255:0] INIT_CHAIN = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ===== hw/rtl/sha_stream_if.sv =====
// Valid/ready channels of the SHA-256 hasher: message items in, digests out.
// No dependencies.
`timescale 1ns / 1ps

interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;

    modport source (output valid, data_byte, has_byte, is_last, input ready);
    modport sink (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_part0;
    logic [63:0] digest_part1;
    logic [63:0] digest_part2;
    logic [63:0] digest_part3;

    modport source (output valid, digest_part0, digest_part1, digest_part2, digest_part3,
                    input ready);
    modport sink (input valid, digest_part0, digest_part1, digest_part2, digest_part3,
                  output ready);
endinterface

// ===== hw/rtl/sha_core.sv =====
// SHA-256 compression datapath: 512-bit block/schedule shift line, one shared
// round unit, working and chaining words. Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sha_pkg::core_ctl_t  ctl,
    output logic [255:0]        chain
);

    logic [511:0] w_reg;
    logic [511:0] w_next;
    logic [255:0] v_reg;
    logic [255:0] v_next;
    logic [255:0] h_reg;
    logic [255:0] h_next;

    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
    logic [31:0] w0, w1, w9, w14;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [255:0] h_sum;

    assign {va, vb, vc, vd, ve, vf, vg, vh} = v_reg;
    assign w0  = w_reg[511:480];
    assign w1  = w_reg[479:448];
    assign w9  = w_reg[223:192];
    assign w14 = w_reg[63:32];

    assign w_new = sha_pkg::small1(w14) + w9 + sha_pkg::small0(w1) + w0;
    assign t1 = vh + sha_pkg::big1(ve) + ((ve & vf) ^ (~ve & vg))
              + sha_pkg::K_TABLE[ctl.round] + w0;
    assign t2 = sha_pkg::big0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_sum[i*32 +: 32] = h_reg[i*32 +: 32] + v_reg[i*32 +: 32];
        end
    end

    always_comb
    begin
        w_next = w_reg;
        v_next = v_reg;
        h_next = h_reg;
        unique case (ctl.op)
            sha_pkg::CORE_BYTE:
            begin
                w_next = {w_reg[503:0], ctl.byte_val};
            end
            sha_pkg::CORE_ROUND:
            begin
                w_next = {w_reg[479:0], w_new};
                v_next = {t1 + t2, va, vb, vc, vd + t1, ve, vf, vg};
            end
            sha_pkg::CORE_UPDATE:
            begin
                h_next = h_sum;
                v_next = h_sum;
            end
            sha_pkg::CORE_INIT:
            begin
                h_next = sha_pkg::INIT_CHAIN;
                v_next = sha_pkg::INIT_CHAIN;
            end
            sha_pkg::CORE_HOLD:
            begin
                w_next = w_reg;
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= sha_pkg::INIT_CHAIN;
            h_reg <= sha_pkg::INIT_CHAIN;
        end
        else
        begin
            v_reg <= v_next;
            h_reg <= h_next;
        end
    end

    assign chain = h_reg;

endmodule

// ===== hw/rtl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher: one byte item per cycle while idle; a full block costs
// 64 rounds plus one chaining update in the shared round unit, during which no
// item is accepted. Last item: padding and length bytes go in one per cycle, then
// one or two compressions and a load of the digest once the output register is free.
// Async active-low reset restores the initial chaining words and an empty
// message. Depends on sha_pkg, sha_core and the sha_in_if / sha_out_if interfaces.
`timescale 1ns / 1ps

module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    sha_in_if.sink      msg,
    sha_out_if.source   digest
);

    sha_pkg::state_t     state_reg;
    sha_pkg::state_t     state_next;
    logic [5:0]          fill_reg;
    logic [5:0]          fill_next;
    logic [5:0]          round_reg;
    logic [5:0]          round_next;
    logic [63:0]         total_reg;
    logic [63:0]         total_next;
    logic [63:0]         len_reg;
    logic [63:0]         len_next;
    logic                finish_reg;
    logic                finish_next;
    logic                first_reg;
    logic                first_next;
    logic                final_reg;
    logic                final_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [255:0]        digest_reg;
    logic [255:0]        digest_next;

    logic                accept;
    logic                inject;
    logic [7:0]          inject_byte;
    logic                block_full;
    logic                emit_load;
    logic [63:0]         total_inc;
    sha_pkg::core_ctl_t  core_ctl;
    logic [255:0]        chain;

    sha_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (core_ctl),
        .chain (chain)
    );

    assign msg.ready = (state_reg == sha_pkg::ST_IDLE);
    assign accept = msg.valid && msg.ready;
    assign emit_load = (state_reg == sha_pkg::ST_EMIT) && (!out_valid_reg || digest.ready);
    assign total_inc = (accept && msg.has_byte) ? total_reg + 64'd1 : total_reg;

    always_comb
    begin
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                inject      = accept && msg.has_byte;
                inject_byte = msg.data_byte;
            end
            sha_pkg::ST_PAD:
            begin
                inject      = 1'b1;
                inject_byte = first_reg ? sha_pkg::PAD_MARK : sha_pkg::PAD_ZERO;
            end
            sha_pkg::ST_LEN:
            begin
                inject      = 1'b1;
                inject_byte = len_reg[63:56];
            end
            default:
            begin
                inject      = 1'b0;
                inject_byte = sha_pkg::PAD_ZERO;
            end
        endcase
    end

    assign block_full = inject && (fill_reg == sha_pkg::LAST_SLOT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (block_full)
                        state_next = sha_pkg::ST_ROUND;
                    else if (msg.is_last)
                        state_next = sha_pkg::ST_PAD;
                    else
                        state_next = state_reg;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (round_reg == sha_pkg::LAST_ROUND)
                    state_next = sha_pkg::ST_UPDATE;
            end
            sha_pkg::ST_UPDATE:
            begin
                priority if (final_reg)
                    state_next = sha_pkg::ST_EMIT;
                else if (finish_reg)
                    state_next = sha_pkg::ST_PAD;
                else
                    state_next = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_PAD:
            begin
                priority if (block_full)
                    state_next = sha_pkg::ST_ROUND;
                else if (fill_reg == sha_pkg::LEN_START_SLOT)
                    state_next = sha_pkg::ST_LEN;
                else
                    state_next = state_reg;
            end
            sha_pkg::ST_LEN:
            begin
                if (block_full)
                    state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_EMIT:
            begin
                if (emit_load)
                    state_next = sha_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_next      = inject ? fill_reg + 6'd1 : fill_reg;
        total_next     = emit_load ? 64'd0 : total_inc;
        round_next     = (state_reg == sha_pkg::ST_ROUND) ? round_reg + 6'd1 : round_reg;
        len_next       = len_reg;
        finish_next    = finish_reg;
        first_next     = first_reg;
        final_next     = final_reg;
        core_ctl.byte_val = inject_byte;
        core_ctl.round    = round_reg;
        core_ctl.op       = sha_pkg::CORE_HOLD;

        if (accept && msg.is_last)
        begin
            finish_next = 1'b1;
            first_next  = 1'b1;
            len_next    = {total_inc[60:0], 3'b000};
        end
        if (state_reg == sha_pkg::ST_PAD)
            first_next = 1'b0;
        if (state_reg == sha_pkg::ST_LEN)
            len_next = {len_reg[55:0], 8'h00};
        if (state_reg == sha_pkg::ST_LEN && block_full)
            final_next = 1'b1;
        if (emit_load)
        begin
            finish_next = 1'b0;
            final_next  = 1'b0;
        end

        priority if (inject)
            core_ctl.op = sha_pkg::CORE_BYTE;
        else if (state_reg == sha_pkg::ST_ROUND)
            core_ctl.op = sha_pkg::CORE_ROUND;
        else if (state_reg == sha_pkg::ST_UPDATE)
            core_ctl.op = sha_pkg::CORE_UPDATE;
        else if (emit_load)
            core_ctl.op = sha_pkg::CORE_INIT;
        else
            core_ctl.op = sha_pkg::CORE_HOLD;

        out_valid_next = emit_load || (out_valid_reg && !digest.ready);
        digest_next    = emit_load ? chain : digest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha_pkg::ST_IDLE;
            fill_reg      <= 6'd0;
            round_reg     <= 6'd0;
            total_reg     <= 64'd0;
            finish_reg    <= 1'b0;
            first_reg     <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            total_reg     <= total_next;
            finish_reg    <= finish_next;
            first_reg     <= first_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        digest_reg <= digest_next;
    end

    assign digest.valid        = out_valid_reg;
    assign digest.digest_part0 = digest_reg[255:192];
    assign digest.digest_part1 = digest_reg[191:128];
    assign digest.digest_part2 = digest_reg[127:64];
    assign digest.digest_part3 = digest_reg[63:0];

endmodule

// ===== hw/rtl/sha_chk.sv =====
// Port-level checks of the SHA-256 hasher, bound to the top level.
// Depends on assert_macros.svh and sha256_stream_hasher.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_has_byte,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_part0
);

    logic in_accept;

    assign in_accept = in_valid && in_ready;

    `CHK_NEXT(a_last_busy, clk, rst_n, in_accept && in_last, !in_ready, "idle after last item")
    `CHK_NEXT(a_empty_idle, clk, rst_n, in_accept && !in_has_byte && !in_last, in_ready, "busy after empty item")
    `CHK_SAME(a_digest_after_busy, clk, rst_n, $rose(out_valid), $past(!in_ready), "digest while idle")
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_part0), "stalled digest dropped")

endmodule

bind sha256_stream_hasher sha_chk u_sha_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (msg.valid),
    .in_ready    (msg.ready),
    .in_has_byte (msg.has_byte),
    .in_last     (msg.is_last),
    .out_valid   (digest.valid),
    .out_ready   (digest.ready),
    .out_part0   (digest.digest_part0)
);

// ===== tb/sv/tb_sha256_stream_hasher.sv =====
// Self-checking testbench for sha256_stream_hasher: streams random and corner-case messages,
// predicts each digest with an in-bench SHA-256 and compares it against the block output.
// Depends on the sha_in_if / sha_out_if interfaces and the hasher RTL.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 400;

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef logic [3:0][63:0] digest_t;

    logic clk;
    logic rst_n;

    sha_in_if  msg ();
    sha_out_if digest ();

    sha256_stream_hasher u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .digest (digest)
    );

    logic [31:0] hash_word [8];
    logic [7:0]  block_buf [64];
    int          fill_level;
    logic [63:0] byte_count;

    digest_t     digest_q [$];
    digest_t     want_digest;
    digest_t     got_digest;

    int          errors;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {block_buf[4 * i], block_buf[4 * i + 1],
                    block_buf[4 * i + 2], block_buf[4 * i + 3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            w[i] = w[i - 16] + w[i - 7]
                 + (rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3))
                 + (rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10));
        end
        for (int i = 0; i < 8; i++)
            v[i] = hash_word[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_word[i] = hash_word[i] + v[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            hash_word[i] = IV_WORDS[i];
        fill_level = 0;
        byte_count = '0;
    endfunction

    // Advance the predicted hash state by one accepted item.
    function automatic void hash_absorb(input logic [7:0] b, input logic hb, input logic lst);
        logic [63:0] bit_len;
        digest_t     d;
        if (hb)
        begin
            block_buf[fill_level] = b;
            fill_level++;
            byte_count = byte_count + 64'd1;
            if (fill_level == 64)
            begin
                compress_block();
                fill_level = 0;
            end
        end
        if (!lst)
            return;
        bit_len = byte_count << 3;
        block_buf[fill_level] = 8'h80;
        fill_level++;
        if (fill_level > 56)
        begin
            while (fill_level < 64)
            begin
                block_buf[fill_level] = 8'h00;
                fill_level++;
            end
            compress_block();
            fill_level = 0;
        end
        while (fill_level < 56)
        begin
            block_buf[fill_level] = 8'h00;
            fill_level++;
        end
        for (int i = 0; i < 8; i++)
            block_buf[56 + i] = bit_len[63 - 8 * i -: 8];
        compress_block();
        for (int i = 0; i < 4; i++)
            d[i] = {hash_word[2 * i], hash_word[2 * i + 1]};
        digest_q.push_back(d);
        restart_message();
    endfunction

    task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            msg.valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        msg.valid     <= 1'b1;
        msg.data_byte <= b;
        msg.has_byte  <= hb;
        msg.is_last   <= lst;
        @(posedge clk);
        while (!msg.ready)
            @(posedge clk);
        hash_absorb(b, hb, lst);
    endtask

    task automatic send_noise();
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
    endtask

    // Send one message; the last flag rides on the final byte or on a byte-less item.
    task automatic send_message(input int len, output int sent);
        bit tail_alone;
        tail_alone = (len == 0) || ($urandom_range(1) == 1);
        sent = 0;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 5)
                send_noise();
            send_item(8'($urandom_range(255)), 1'b1, !tail_alone && (i == len - 1));
            sent++;
        end
        if (tail_alone)
        begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
            sent++;
        end
    endtask

    function automatic int pick_length();
        int sel;
        int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom_range(40);
        else if (sel < 92)
            return edges[$urandom_range(9)];
        else
            return $urandom_range(200, 129);
    endfunction

    task automatic run_random_messages(input int item_budget);
        int total;
        int sent;
        total = 0;
        while (total < item_budget)
        begin
            if ($urandom_range(99) < 4)
                send_noise();
            send_message(pick_length(), sent);
            total += sent;
        end
    endtask

    task automatic test_corner_messages();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'ha5, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h3c, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        send_item(8'h7f, 1'b1, 1'b1);
        send_item(8'h01, 1'b1, 1'b1);
    endtask

    task automatic test_flow_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_messages(200);
    endtask

    task automatic test_flow_sender_idle();
        send_idle_pct  = 57;
        recv_stall_pct = 0;
        run_random_messages(200);
    endtask

    task automatic test_flow_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        run_random_messages(200);
    endtask

    task automatic test_flow_both_idle();
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        run_random_messages(200);
    endtask

    always @(negedge clk)
        digest.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && digest.valid && digest.ready)
        begin
            got_digest[0] = digest.digest_part0;
            got_digest[1] = digest.digest_part1;
            got_digest[2] = digest.digest_part2;
            got_digest[3] = digest.digest_part3;
            if (digest_q.size() == 0)
            begin
                $display("%0t: unexpected digest, expected none actual %h", $time, got_digest);
                errors++;
            end
            else
            begin
                want_digest = digest_q.pop_front();
                for (int i = 0; i < 4; i++)
                begin
                    if (got_digest[i] !== want_digest[i])
                    begin
                        $display("%0t: digest_part%0d expected %h actual %h",
                                 $time, i, want_digest[i], got_digest[i]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        errors         = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        msg.valid      = 1'b0;
        msg.data_byte  = 8'h00;
        msg.has_byte   = 1'b0;
        msg.is_last    = 1'b0;
        digest.ready   = 1'b0;
        restart_message();
        for (int i = 0; i < 64; i++)
            block_buf[i] = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_messages();
        test_flow_no_idle();
        test_flow_sender_idle();
        test_flow_receiver_stall();
        test_flow_both_idle();

        @(negedge clk);
        msg.valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
